/* hdl/rmeu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmeu_pkg
// Shared types and constants for the register machine execute unit.
// ----------------------------------------------------------------------------
package rmeu_pkg;

   localparam int REG_COUNT_DEFAULT = 8;
   localparam int QUEUE_DEPTH       = 2;

   typedef enum logic [3:0] {
      CMD_CMOV  = 4'd0,
      CMD_ADD   = 4'd1,
      CMD_MUL   = 4'd2,
      CMD_DIV   = 4'd3,
      CMD_NAND  = 4'd4,
      CMD_OUT   = 4'd5,
      CMD_IN    = 4'd6,
      CMD_LOADI = 4'd7,
      CMD_LOADP = 4'd8
   } command_type;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_DIV0 = 2'd1,
      FAULT_OUT  = 2'd2
   } fault_type;

   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
   localparam logic [31:0] CHAR_MAX_VAL = 32'd255;

   // operation class chosen by the front end
   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0,
      CLS_MUL    = 2'd1,
      CLS_DIV    = 2'd2,
      CLS_NOP    = 2'd3
   } op_class_type;

   typedef struct packed {
      logic [3:0]   command;
      op_class_type op_class;
      logic [2:0]   reg_a;
      logic [2:0]   reg_b;
      logic [2:0]   reg_c;
      logic [31:0]  immediate;
      logic [7:0]   in_char;
      logic         in_end;
   } op_type;

   typedef struct packed {
      logic        char_valid;
      logic [7:0]  out_char;
      logic        jump_valid;
      logic [31:0] jump_target;
      logic        copy_request;
      logic [31:0] segment_id;
      logic [1:0]  fault;
   } result_type;

endpackage
`default_nettype wire

/* hdl/rmeu_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmeu_req_if / rmeu_rsp_if
// Valid/ready channels carrying instructions and results.
// ----------------------------------------------------------------------------
interface rmeu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  command;
   logic [2:0]  reg_a;
   logic [2:0]  reg_b;
   logic [2:0]  reg_c;
   logic [31:0] immediate;
   logic [7:0]  in_char;
   logic        in_end;
   modport source (output valid, command, reg_a, reg_b, reg_c, immediate, in_char,
                   in_end, input ready);
   modport sink   (input valid, command, reg_a, reg_b, reg_c, immediate, in_char,
                   in_end, output ready);
endinterface

interface rmeu_rsp_if;
   logic        valid;
   logic        ready;
   logic        char_valid;
   logic [7:0]  out_char;
   logic        jump_valid;
   logic [31:0] jump_target;
   logic        copy_request;
   logic [31:0] segment_id;
   logic [1:0]  fault;
   modport source (output valid, char_valid, out_char, jump_valid, jump_target,
                   copy_request, segment_id, fault, input ready);
   modport sink   (input valid, char_valid, out_char, jump_valid, jump_target,
                   copy_request, segment_id, fault, output ready);
endinterface
`default_nettype wire

/* hdl/register_machine_execute_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// Decoupled execute unit for a 32-bit register machine.
// ----------------------------------------------------------------------------
// Instructions enter a two-entry queue and run one at a time against a
// register file of REG_COUNT words, each giving one result. An instruction
// starts in the back end at the edge after it is queued, and only when the
// result register is empty or its result is taken in that cycle. Move, add,
// nand, output, input, load immediate, load program, unused commands and a
// divide by zero finish at their start edge, so the result is registered at
// that edge and one such instruction per cycle can follow while results
// are taken at once. Multiply and divide run a shift-add or restoring loop
// after they start, and the back end takes the next instruction only once
// that loop has ended. A result left waiting holds the back end, and the
// queue then fills and stalls requests.
module register_machine_execute_unit #(
   parameter int REG_COUNT = rmeu_pkg::REG_COUNT_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   rmeu_req_if.sink   req,
   rmeu_rsp_if.source rsp
);
   rmeu_pkg::op_type op;
   logic op_valid, op_take;

   rmeu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .op_out   (op),
      .op_valid (op_valid),
      .op_take  (op_take)
   );

   rmeu_back #(.REG_COUNT(REG_COUNT)) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_in    (op),
      .op_valid (op_valid),
      .op_take  (op_take),
      .rsp      (rsp)
   );
endmodule
`default_nettype wire

/* hdl/rmeu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmeu_front
// Accepts instructions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rmeu_front (
   input  wire logic           clock,
   input  wire logic           reset,
   rmeu_req_if.sink            req,
   output rmeu_pkg::op_type    op_out,
   output logic                op_valid,
   input  wire logic           op_take
);
   localparam int QD = rmeu_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(QD);

   rmeu_pkg::op_type q_ff [QD];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   rmeu_pkg::op_type op_new;
   logic push, pop;

   always_comb begin
      op_new.command   = req.command;
      op_new.reg_a     = req.reg_a;
      op_new.reg_b     = req.reg_b;
      op_new.reg_c     = req.reg_c;
      op_new.immediate = req.immediate;
      op_new.in_char   = req.in_char;
      op_new.in_end    = req.in_end;
      if (req.command == rmeu_pkg::CMD_MUL) begin
         op_new.op_class = rmeu_pkg::CLS_MUL;
      end else if (req.command == rmeu_pkg::CMD_DIV) begin
         op_new.op_class = rmeu_pkg::CLS_DIV;
      end else if (req.command > rmeu_pkg::CMD_LOADP) begin
         op_new.op_class = rmeu_pkg::CLS_NOP;
      end else begin
         op_new.op_class = rmeu_pkg::CLS_SIMPLE;
      end
   end

   assign req.ready = (cnt_ff != (PW+1)'(QD));
   assign push      = req.valid && req.ready;
   assign op_valid  = (cnt_ff != '0);
   assign pop       = op_valid && op_take;
   assign op_out    = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= op_new;
      end
   end
endmodule
`default_nettype wire

/* hdl/rmeu_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmeu_back
// Executes queued instructions: register file, shift-add multiplier,
// restoring divider and result register.
// ----------------------------------------------------------------------------
module rmeu_back #(
   parameter int REG_COUNT = rmeu_pkg::REG_COUNT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rmeu_pkg::op_type op_in,
   input  wire logic             op_valid,
   output logic                  op_take,
   rmeu_rsp_if.source            rsp
);
   localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV
   } state_type;

   state_type state_ff;
   logic [31:0] regs_ff [REG_COUNT];
   logic [31:0] acc_ff;     // product accumulator
   logic [31:0] rem_ff;
   logic [31:0] opb_ff;     // multiplicand / dividend shift
   logic [31:0] opc_ff;     // multiplier / divisor
   logic [4:0]  step_ff;
   logic [IW-1:0] dst_ff;
   logic        rsp_valid_ff;
   rmeu_pkg::result_type res_ff;

   logic [IW-1:0] ia, ib, ic;
   logic [31:0]   vb, vc;
   logic          out_free;
   logic          start;
   logic          mul_done;
   logic          div_done;
   logic          rsp_fire;
   logic [32:0]   rem_sh;
   logic [32:0]   rem_sub;
   rmeu_pkg::result_type res_in;

   // register index modulo REG_COUNT (for REG_COUNT of two or more) by up to three compare and subtract steps
   function automatic logic [IW-1:0] idx(input logic [2:0] v);
      logic [4:0] w;
      w = {2'b00, v};
      for (int k = 0; k < 3; k++) begin
         if (w >= 5'(REG_COUNT)) begin
            w = w - 5'(REG_COUNT);
         end
      end
      return IW'(w);
   endfunction

   assign ia = idx(op_in.reg_a);
   assign ib = idx(op_in.reg_b);
   assign ic = idx(op_in.reg_c);
   assign vb = regs_ff[ib];
   assign vc = regs_ff[ic];

   assign out_free = !rsp_valid_ff || rsp.ready;
   // every instruction leaves the queue when it starts
   assign start    = (state_ff == ST_IDLE) && op_valid && out_free;
   assign op_take  = start;

   assign mul_done = (state_ff == ST_MUL) && (step_ff == 5'd31);
   assign div_done = (state_ff == ST_DIV) && (step_ff == 5'd31);
   assign rsp_fire = (start && (op_in.op_class != rmeu_pkg::CLS_MUL)
                      && !((op_in.op_class == rmeu_pkg::CLS_DIV) && (vc != '0)))
                     || mul_done || div_done;

   // one restoring division step
   assign rem_sh  = {rem_ff, opb_ff[31]};
   assign rem_sub = rem_sh - {1'b0, opc_ff};

   always_comb begin
      res_in = '0;
      unique case (op_in.command)
         rmeu_pkg::CMD_DIV: begin
            if (vc == '0) begin
               res_in.fault = rmeu_pkg::FAULT_DIV0;
            end
         end
         rmeu_pkg::CMD_OUT: begin
            if (vc > rmeu_pkg::CHAR_MAX_VAL) begin
               res_in.fault = rmeu_pkg::FAULT_OUT;
            end else begin
               res_in.char_valid = 1'b1;
               res_in.out_char   = vc[7:0];
            end
         end
         rmeu_pkg::CMD_LOADP: begin
            res_in.jump_valid   = 1'b1;
            res_in.jump_target  = vc;
            res_in.copy_request = (vb != '0);
            res_in.segment_id   = vb;
         end
         default: ;
      endcase
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.char_valid   = res_ff.char_valid;
   assign rsp.out_char     = res_ff.out_char;
   assign rsp.jump_valid   = res_ff.jump_valid;
   assign rsp.jump_target  = res_ff.jump_target;
   assign rsp.copy_request = res_ff.copy_request;
   assign rsp.segment_id   = res_ff.segment_id;
   assign rsp.fault        = res_ff.fault;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         res_ff       <= '0;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  dst_ff <= ia;
                  res_ff <= res_in;
                  unique case (op_in.op_class)
                     rmeu_pkg::CLS_MUL: begin
                        acc_ff   <= '0;
                        opb_ff   <= vb;
                        opc_ff   <= vc;
                        step_ff  <= '0;
                        state_ff <= ST_MUL;
                     end
                     rmeu_pkg::CLS_DIV: begin
                        if (vc != '0) begin
                           rem_ff   <= '0;
                           opb_ff   <= vb;
                           opc_ff   <= vc;
                           step_ff  <= '0;
                           state_ff <= ST_DIV;
                        end
                     end
                     rmeu_pkg::CLS_SIMPLE: begin
                        unique case (op_in.command)
                           rmeu_pkg::CMD_CMOV:
                              if (vc != '0) regs_ff[ia] <= vb;
                           rmeu_pkg::CMD_ADD:   regs_ff[ia] <= vb + vc;
                           rmeu_pkg::CMD_NAND:  regs_ff[ia] <= ~(vb & vc);
                           rmeu_pkg::CMD_IN:
                              regs_ff[ic] <= op_in.in_end ? rmeu_pkg::ALL_ONES
                                                          : {24'd0, op_in.in_char};
                           rmeu_pkg::CMD_LOADI: regs_ff[ia] <= op_in.immediate;
                           default: ;
                        endcase
                     end
                     rmeu_pkg::CLS_NOP: ;
                  endcase
               end
            end
            ST_MUL: begin
               // shift-add, one multiplier bit per cycle
               if (opc_ff[0]) begin
                  acc_ff <= acc_ff + opb_ff;
               end
               opb_ff  <= {opb_ff[30:0], 1'b0};
               opc_ff  <= {1'b0, opc_ff[31:1]};
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd31) begin
                  regs_ff[dst_ff] <= opc_ff[0] ? acc_ff + opb_ff : acc_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            ST_DIV: begin
               // quotient bits shift into opb_ff as dividend bits leave
               if (!rem_sub[32]) begin
                  rem_ff <= rem_sub[31:0];
               end else begin
                  rem_ff <= rem_sh[31:0];
               end
               opb_ff  <= {opb_ff[30:0], !rem_sub[32]};
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd31) begin
                  regs_ff[dst_ff] <= {opb_ff[30:0], !rem_sub[32]};
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
